// ----- design/sbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, codes and helpers for the stack bytecode executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF  = 16;
    localparam int PROGRAM_SIZE_DEF = 256;

    localparam int WORD_W = 32;

    // request types
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_EXEC   = 2'd1;
    localparam logic [1:0] REQ_RDRESP = 2'd2;

    // opcode keys (high nibble) and the terminator byte
    localparam logic [3:0] KEY_PUSH = 4'h0;
    localparam logic [3:0] KEY_PRIM = 4'h5;
    localparam logic [3:0] KEY_POPN = 4'h7;
    localparam logic [3:0] KEY_JMP  = 4'h8;
    localparam logic [3:0] KEY_JNE  = 4'h9;
    localparam logic [3:0] KEY_JNZ  = 4'hA;
    localparam logic [7:0] BC_HALT  = 8'hFF;

    // primitive selectors (low nibble)
    localparam logic [3:0] PRIM_RD_VAL  = 4'd0;
    localparam logic [3:0] PRIM_WR_VAL  = 4'd1;
    localparam logic [3:0] PRIM_RD_MODE = 4'd2;
    localparam logic [3:0] PRIM_WR_MODE = 4'd3;
    localparam logic [3:0] PRIM_DELAY   = 4'd4;

    // pin request codes
    localparam logic [2:0] IO_NONE    = 3'd0;
    localparam logic [2:0] IO_RD_VAL  = 3'd1;
    localparam logic [2:0] IO_WR_VAL  = 3'd2;
    localparam logic [2:0] IO_RD_MODE = 3'd3;
    localparam logic [2:0] IO_WR_MODE = 3'd4;
    localparam logic [2:0] IO_DELAY   = 3'd5;

    // stack cell control: push a word or drop pop_n words from the top
    typedef struct packed {
        logic              push;
        logic [3:0]        pop_n;
        logic [WORD_W-1:0] word;
    } t_stk_ctrl;

    // one result item
    typedef struct packed {
        logic [7:0]        next_ip;
        logic              run_done;
        logic              stack_error;
        logic [2:0]        io_op;
        logic [7:0]        io_pin;
        logic [WORD_W-1:0] io_data;
        logic              awaiting_read;
    } t_result;

    // integer part of a Q16.16 word, clamped to 0..255
    function automatic logic [7:0] to_byte(input logic [WORD_W-1:0] q);
        logic [7:0] r;
        if (q[31]) begin
            r = 8'd0;
        end else if (q[30:24] != 7'd0) begin
            r = 8'hFF;
        end else begin
            r = q[23:16];
        end
        return r;
    endfunction

    // integer part of a Q16.16 word, negatives give zero
    function automatic logic [WORD_W-1:0] to_ms(input logic [WORD_W-1:0] q);
        logic [WORD_W-1:0] r;
        if (q[31]) begin
            r = '0;
        end else begin
            r = {16'd0, q[31:16]};
        end
        return r;
    endfunction

endpackage

// ----- design/sbe_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_cell
// One stack slot. Slot 0 is the top; pushes move words one slot deeper,
// pops lift words up by the number popped.
// ----------------------------------------------------------------------------
module sbe_cell #(
    parameter int IDX   = 0,
    parameter int DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  sbe_pkg::t_stk_ctrl          i_ctrl,
    input  logic [sbe_pkg::WORD_W-1:0]  i_words [DEPTH],
    output logic [sbe_pkg::WORD_W-1:0]  o_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH + 16);

    logic [sbe_pkg::WORD_W-1:0] r_word;
    logic [sbe_pkg::WORD_W-1:0] n_word;
    logic [sbe_pkg::WORD_W-1:0] w_above;
    logic [SW-1:0]              w_src;

    // word handed down on a push
    generate
        if (IDX == 0) begin : g_top
            assign w_above = i_ctrl.word;
        end else begin : g_deep
            assign w_above = i_words[IDX-1];
        end
    endgenerate

    assign w_src = SW'(IDX) + SW'(i_ctrl.pop_n);

    // select the next slot content
    always_comb begin
        n_word = r_word;
        if (i_ctrl.push) begin
            n_word = w_above;
        end else if (i_ctrl.pop_n != 4'd0) begin
            if (w_src < SW'(DEPTH)) begin
                n_word = i_words[w_src[AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- design/sbe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_ctrl
// Decodes one request, keeps pointer, stack count and run flags, drives the
// stack cells and forms the result.
// ----------------------------------------------------------------------------
module sbe_ctrl #(
    parameter int STACK_DEPTH  = sbe_pkg::STACK_DEPTH_DEF,
    parameter int PROGRAM_SIZE = sbe_pkg::PROGRAM_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_req_type,
    input  logic [7:0]                  i_bytecode,
    input  logic [sbe_pkg::WORD_W-1:0]  i_literal_word,
    input  logic [sbe_pkg::WORD_W-1:0]  i_read_data,
    input  logic [sbe_pkg::WORD_W-1:0]  i_top0,
    input  logic [sbe_pkg::WORD_W-1:0]  i_top1,
    output sbe_pkg::t_stk_ctrl          o_stk,
    output sbe_pkg::t_result            o_result
);

    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int XW  = (CW > 4) ? CW : 4;
    localparam int IPW = $clog2(PROGRAM_SIZE);
    localparam int IPX = (IPW > 8) ? IPW : 8;

    logic [IPW-1:0] r_ip,   n_ip;
    logic [CW-1:0]  r_cnt,  n_cnt;
    logic           r_pend, n_pend;
    logic           r_err,  n_err;

    sbe_pkg::t_stk_ctrl w_stk;
    logic [3:0]     w_key;
    logic [3:0]     w_val;
    logic           w_pop1_ok;
    logic           w_pop2_ok;
    logic           w_full;
    logic [IPW:0]   w_inc_sum;
    logic [IPW-1:0] w_ip_inc;
    logic [IPW:0]   w_jmp_sum;
    logic [IPW-1:0] w_ip_jmp;
    logic [IPX-1:0] w_ip_ext;
    logic           w_jump;
    logic           w_err_now;
    logic           w_done_now;
    logic [2:0]     w_op;
    logic [7:0]     w_pin;
    logic [sbe_pkg::WORD_W-1:0] w_data;

    assign w_key     = i_bytecode[7:4];
    assign w_val     = i_bytecode[3:0];
    assign w_pop1_ok = (r_cnt != '0);
    assign w_pop2_ok = (r_cnt >= CW'(2));
    assign w_full    = (r_cnt >= CW'(STACK_DEPTH));

    // advance and jump targets, wrapped to the program size
    assign w_inc_sum = {1'b0, r_ip} + (IPW+1)'(1);
    assign w_ip_inc  = (w_inc_sum == (IPW+1)'(PROGRAM_SIZE)) ? '0 : w_inc_sum[IPW-1:0];
    assign w_jmp_sum = {1'b0, w_ip_inc} + (IPW+1)'(w_val);
    assign w_ip_jmp  = (w_jmp_sum >= (IPW+1)'(PROGRAM_SIZE))
                     ? IPW'(w_jmp_sum - (IPW+1)'(PROGRAM_SIZE))
                     : w_jmp_sum[IPW-1:0];

    // decode one request
    always_comb begin
        n_ip       = r_ip;
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        n_err      = r_err;
        w_stk      = '0;
        w_jump     = 1'b0;
        w_err_now  = 1'b0;
        w_done_now = 1'b0;
        w_op       = sbe_pkg::IO_NONE;
        w_pin      = 8'd0;
        w_data     = '0;
        unique case (i_req_type)
            sbe_pkg::REQ_START: begin
                n_ip   = '0;
                n_cnt  = '0;
                n_pend = 1'b0;
                n_err  = 1'b0;
            end
            sbe_pkg::REQ_RDRESP: begin
                if (r_pend && !r_err) begin
                    n_pend = 1'b0;
                    if (w_full) begin
                        w_err_now = 1'b1;
                    end else begin
                        w_stk.push = 1'b1;
                        w_stk.word = i_read_data;
                        n_cnt      = r_cnt + CW'(1);
                    end
                end
            end
            sbe_pkg::REQ_EXEC: begin
                if (!r_err && !r_pend) begin
                    n_ip = w_ip_inc;
                    if (i_bytecode == sbe_pkg::BC_HALT) begin
                        w_done_now = 1'b1;
                    end else begin
                        unique case (w_key)
                            sbe_pkg::KEY_PUSH: begin
                                if (w_full) begin
                                    w_err_now = 1'b1;
                                end else begin
                                    w_stk.push = 1'b1;
                                    w_stk.word = i_literal_word;
                                    n_cnt      = r_cnt + CW'(1);
                                end
                            end
                            sbe_pkg::KEY_PRIM: begin
                                unique case (w_val)
                                    sbe_pkg::PRIM_RD_VAL, sbe_pkg::PRIM_RD_MODE: begin
                                        if (w_pop1_ok) begin
                                            n_cnt       = r_cnt - CW'(1);
                                            w_stk.pop_n = 4'd1;
                                            w_op        = (w_val == sbe_pkg::PRIM_RD_VAL)
                                                        ? sbe_pkg::IO_RD_VAL
                                                        : sbe_pkg::IO_RD_MODE;
                                            w_pin       = sbe_pkg::to_byte(i_top0);
                                            n_pend      = 1'b1;
                                        end else begin
                                            w_err_now = 1'b1;
                                        end
                                    end
                                    sbe_pkg::PRIM_WR_VAL, sbe_pkg::PRIM_WR_MODE: begin
                                        if (w_pop2_ok) begin
                                            n_cnt       = r_cnt - CW'(2);
                                            w_stk.pop_n = 4'd2;
                                            w_pin       = sbe_pkg::to_byte(i_top1);
                                            if (w_val == sbe_pkg::PRIM_WR_VAL) begin
                                                w_op   = sbe_pkg::IO_WR_VAL;
                                                w_data = i_top0;
                                            end else begin
                                                w_op   = sbe_pkg::IO_WR_MODE;
                                                w_data = {24'd0, sbe_pkg::to_byte(i_top0)};
                                            end
                                        end else begin
                                            n_cnt     = '0;
                                            w_err_now = 1'b1;
                                        end
                                    end
                                    sbe_pkg::PRIM_DELAY: begin
                                        if (w_pop1_ok) begin
                                            n_cnt       = r_cnt - CW'(1);
                                            w_stk.pop_n = 4'd1;
                                            w_op        = sbe_pkg::IO_DELAY;
                                            w_data      = sbe_pkg::to_ms(i_top0);
                                        end else begin
                                            w_err_now = 1'b1;
                                        end
                                    end
                                    default: begin
                                        w_op = sbe_pkg::IO_NONE;
                                    end
                                endcase
                            end
                            sbe_pkg::KEY_POPN: begin
                                if (XW'(w_val) <= XW'(r_cnt)) begin
                                    n_cnt       = CW'(XW'(r_cnt) - XW'(w_val));
                                    w_stk.pop_n = w_val;
                                end else begin
                                    n_cnt     = '0;
                                    w_err_now = 1'b1;
                                end
                            end
                            sbe_pkg::KEY_JMP: begin
                                w_jump = 1'b1;
                            end
                            sbe_pkg::KEY_JNE: begin
                                if (w_pop2_ok) begin
                                    n_cnt       = r_cnt - CW'(2);
                                    w_stk.pop_n = 4'd2;
                                    w_jump      = (i_top0 != i_top1);
                                end else begin
                                    n_cnt     = '0;
                                    w_err_now = 1'b1;
                                end
                            end
                            sbe_pkg::KEY_JNZ: begin
                                if (w_pop1_ok) begin
                                    n_cnt       = r_cnt - CW'(1);
                                    w_stk.pop_n = 4'd1;
                                    w_jump      = (i_top0 != '0);
                                end else begin
                                    w_err_now = 1'b1;
                                end
                            end
                            default: begin
                                w_jump = 1'b0;
                            end
                        endcase
                        if (w_jump && !w_err_now) begin
                            n_ip = w_ip_jmp;
                        end
                    end
                end
            end
            default: begin
                n_err = r_err;
            end
        endcase
        if (w_err_now) begin
            n_err = 1'b1;
        end
    end

    // commit state on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip   <= '0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_accept) begin
            r_ip   <= n_ip;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
            r_err  <= n_err;
        end
    end

    // gate cell moves with the handshake
    always_comb begin
        o_stk = w_stk;
        if (!i_accept) begin
            o_stk.push  = 1'b0;
            o_stk.pop_n = 4'd0;
        end
    end

    // form the result item
    assign w_ip_ext = IPX'(n_ip);

    always_comb begin
        o_result.next_ip       = w_ip_ext[7:0];
        o_result.run_done      = w_done_now || n_err;
        o_result.stack_error   = w_err_now;
        o_result.io_op         = w_op;
        o_result.io_pin        = w_pin;
        o_result.io_data       = w_data;
        o_result.awaiting_read = n_pend;
    end

endmodule

// ----- design/sbe_skid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_skid
// Output register with one skid slot, so the request-side ready is taken from
// a register and has no combinational path from the result-side ready.
// ----------------------------------------------------------------------------
module sbe_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sbe_pkg::t_result  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output sbe_pkg::t_result  o_data
);

    logic             r_out_valid,  n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    sbe_pkg::t_result r_out;
    sbe_pkg::t_result r_skid;
    logic             w_take;
    logic             w_load_out;
    logic             w_load_skid;
    logic             w_from_skid;

    assign o_ready = !r_skid_valid;
    assign w_take  = r_out_valid && i_ready;

    // steer incoming results and drain the skid slot
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        w_load_out   = 1'b0;
        w_load_skid  = 1'b0;
        w_from_skid  = 1'b0;
        if (w_take) begin
            if (r_skid_valid) begin
                w_from_skid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_valid) begin
                w_load_out = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_valid && !r_skid_valid) begin
            if (!r_out_valid) begin
                w_load_out  = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                w_load_skid  = 1'b1;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // hold payload unless loaded
    always_ff @(posedge i_clk) begin
        if (w_from_skid) begin
            r_out <= r_skid;
        end else if (w_load_out) begin
            r_out <= i_data;
        end
        if (w_load_skid) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- design/stack_bytecode_executor.sv -----
`timescale 1ns / 1ps
// The result of an accepted request is registered and shown in the cycle after it
// while the result side keeps up; a result that meets a stalled output waits in the skid slot.
// Throughput: one request per cycle; requests are held off only while two
// results are waiting. Each stack cell moves once per cycle, only on an accepted request.
// Reset (synchronous, active low) clears pointer, stack count, pending-read
// and error flags and the output buffer; stack words are not cleared.
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// Runs fetched bytecodes on a Q16.16 value stack held in a row of shift cells
// and issues pin read, write, mode and delay requests.
// ----------------------------------------------------------------------------
module stack_bytecode_executor #(
    parameter int STACK_DEPTH  = sbe_pkg::STACK_DEPTH_DEF,
    parameter int PROGRAM_SIZE = sbe_pkg::PROGRAM_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_req_type,
    input  logic [7:0]          i_bytecode,
    input  logic signed [31:0]  i_literal_word,
    input  logic signed [31:0]  i_read_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_next_ip,
    output logic                o_run_done,
    output logic                o_stack_error,
    output logic [2:0]          o_io_op,
    output logic [7:0]          o_io_pin,
    output logic signed [31:0]  o_io_data,
    output logic                o_awaiting_read
);

    logic                        w_accept;
    logic [sbe_pkg::WORD_W-1:0]  w_words [STACK_DEPTH];
    sbe_pkg::t_stk_ctrl          w_stk;
    sbe_pkg::t_result            w_result;
    sbe_pkg::t_result            w_out;

    assign w_accept = i_in_valid && o_in_ready;

    // decode and state
    sbe_ctrl #(
        .STACK_DEPTH  (STACK_DEPTH),
        .PROGRAM_SIZE (PROGRAM_SIZE)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_req_type     (i_req_type),
        .i_bytecode     (i_bytecode),
        .i_literal_word (i_literal_word),
        .i_read_data    (i_read_data),
        .i_top0         (w_words[0]),
        .i_top1         (w_words[1]),
        .o_stk          (w_stk),
        .o_result       (w_result)
    );

    // row of stack cells, slot 0 on top
    generate
        for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
            sbe_cell #(
                .IDX   (g),
                .DEPTH (STACK_DEPTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_stk),
                .i_words (w_words),
                .o_word  (w_words[g])
            );
        end
    endgenerate

    // result buffer
    sbe_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .o_ready (o_in_ready),
        .i_data  (w_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out)
    );

    assign o_next_ip       = w_out.next_ip;
    assign o_run_done      = w_out.run_done;
    assign o_stack_error   = w_out.stack_error;
    assign o_io_op         = w_out.io_op;
    assign o_io_pin        = w_out.io_pin;
    assign o_io_data       = w_out.io_data;
    assign o_awaiting_read = w_out.awaiting_read;

endmodule
